FILE: rtl/ttl_pkg.sv
package ttl_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_QUOTE   = 3'd3,
        MODE_WORD    = 3'd4
    } ttl_mode_t;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_TEND = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Register map (word index taken from paddr[2])
    localparam logic       REG_QUOTE   = 1'b0;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // Character constants
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_WS_MAX  = 8'd32;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam int          MAX_RES   = 4;
    localparam logic [2:0]  MAX_RES_C = 3'(MAX_RES);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } ttl_entry_t;

    // Up to four results for one byte, entry 0 goes out first
    typedef struct packed {
        ttl_entry_t [MAX_RES-1:0] ent;
        logic [2:0]               cnt;
    } ttl_list_t;

    typedef struct packed {
        ttl_list_t list;
        ttl_mode_t mode_next;
    } ttl_step_t;

    function automatic ttl_entry_t mk_entry(logic [1:0] kind, logic [7:0] ch);
        ttl_entry_t e;
        e.kind = kind;
        e.ch   = (kind == KIND_CHAR) ? ch : CH_NUL;
        return e;
    endfunction

    function automatic ttl_list_t list_push(ttl_list_t l, ttl_entry_t e);
        ttl_list_t r;
        r = l;
        if (l.cnt < MAX_RES_C) begin
            r.ent[l.cnt[1:0]] = e;
            r.cnt = l.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic ttl_list_t list_append(ttl_list_t a, ttl_list_t b);
        ttl_list_t r;
        r = a;
        for (int i = 0; i < MAX_RES; i++) begin
            if (3'(i) < b.cnt) begin
                r = list_push(r, b.ent[i]);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/ttl_decode.sv
module ttl_decode (
    input  logic [7:0]          in_byte,
    input  ttl_pkg::ttl_mode_t  mode,
    input  logic [7:0]          quote_char,
    output ttl_pkg::ttl_step_t  step
);
    import ttl_pkg::*;

    logic      is_zero, is_ws_or_zero, is_single;
    ttl_list_t skip_l, quote_l, word_l, res_l;
    ttl_mode_t skip_m, quote_m, word_m, res_m;

    // Byte classes
    assign is_zero       = (in_byte == CH_NUL);
    assign is_ws_or_zero = (in_byte <= CH_WS_MAX);
    assign is_single     = (in_byte == CH_LBRACE) || (in_byte == CH_RBRACE) ||
                           (in_byte == CH_LPAREN) || (in_byte == CH_RPAREN) ||
                           (in_byte == CH_APOS)   || (in_byte == CH_COMMA);

    // Byte seen at a token start
    always_comb begin
        skip_l = '0;
        skip_m = MODE_SKIP;
        if (is_zero) begin
            skip_l = list_push(skip_l, mk_entry(KIND_END, CH_NUL));
        end else if (is_ws_or_zero) begin
            skip_m = MODE_SKIP;
        end else if (in_byte == CH_SLASH) begin
            skip_m = MODE_SLASH;
        end else if (in_byte == quote_char) begin
            skip_m = MODE_QUOTE;
        end else if (is_single) begin
            skip_l = list_push(skip_l, mk_entry(KIND_CHAR, in_byte));
            skip_l = list_push(skip_l, mk_entry(KIND_TEND, CH_NUL));
        end else begin
            skip_l = list_push(skip_l, mk_entry(KIND_CHAR, in_byte));
            skip_m = MODE_WORD;
        end
    end

    // Byte inside a quoted token
    always_comb begin
        quote_l = '0;
        quote_m = MODE_SKIP;
        if (is_zero) begin
            quote_l = list_push(quote_l, mk_entry(KIND_TEND, CH_NUL));
            quote_l = list_push(quote_l, mk_entry(KIND_END, CH_NUL));
        end else if (in_byte == quote_char) begin
            quote_l = list_push(quote_l, mk_entry(KIND_TEND, CH_NUL));
        end else begin
            quote_l = list_push(quote_l, mk_entry(KIND_CHAR, in_byte));
            quote_m = MODE_QUOTE;
        end
    end

    // Byte inside a word: a delimiter ends it and is then lexed as a token start
    always_comb begin
        word_l = '0;
        if (is_single || is_ws_or_zero) begin
            word_l = list_push(word_l, mk_entry(KIND_TEND, CH_NUL));
            word_l = list_append(word_l, skip_l);
            word_m = skip_m;
        end else begin
            word_l = list_push(word_l, mk_entry(KIND_CHAR, in_byte));
            word_m = MODE_WORD;
        end
    end

    // Mode select
    always_comb begin
        res_l = '0;
        res_m = MODE_SKIP;
        unique case (mode)
            MODE_SLASH: begin
                if (in_byte == CH_SLASH) begin
                    res_m = MODE_COMMENT;
                end else if (quote_char == CH_SLASH) begin
                    res_l = quote_l;
                    res_m = quote_m;
                end else begin
                    res_l = list_push(res_l, mk_entry(KIND_CHAR, CH_SLASH));
                    res_l = list_append(res_l, word_l);
                    res_m = word_m;
                end
            end
            MODE_COMMENT: begin
                if (is_zero) begin
                    res_l = list_push(res_l, mk_entry(KIND_END, CH_NUL));
                end else if (in_byte != CH_NEWLINE) begin
                    res_m = MODE_COMMENT;
                end
            end
            MODE_QUOTE: begin
                res_l = quote_l;
                res_m = quote_m;
            end
            MODE_WORD: begin
                res_l = word_l;
                res_m = word_m;
            end
            default: begin
                res_l = skip_l;
                res_m = skip_m;
            end
        endcase
    end

    assign step.list      = res_l;
    assign step.mode_next = res_m;

endmodule

FILE: rtl/text_token_lexer_unit.sv
// A byte accepted into the input register is lexed into the result list once
// the list is free; its first result is offered from then on.
// One byte per cycle while each byte gives at most one result and m_tready is
// high; a byte with more (up to 4) holds the next byte until its last is taken.
// Reset (aresetn low at a clock edge): mode returns to skip whitespace, quote
// character to 34, input and result stages empty.
module text_token_lexer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_char
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,    // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ttl_pkg::*;

    logic       quote_sel;
    logic [7:0] quote_char_reg;
    ttl_mode_t  mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    ttl_list_t  list_reg, list_next;
    ttl_step_t  step;
    logic       list_free, load, m_take, cfg_wr;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign quote_sel = (paddr[2] == REG_QUOTE);
    assign prdata    = quote_sel ? {24'd0, quote_char_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_char_reg <= QUOTE_RESET;
        end else if (cfg_wr && quote_sel) begin
            quote_char_reg <= pwdata[7:0];
        end
    end

    // Handshake control
    assign m_take    = m_tvalid && m_tready;
    assign list_free = (list_reg.cnt == 3'd0) || ((list_reg.cnt == 3'd1) && m_tready);
    assign load      = in_valid_reg && list_free;
    assign s_tready  = !in_valid_reg || load;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Lexer step
    ttl_decode u_decode (
        .in_byte    (in_byte_reg),
        .mode       (mode_reg),
        .quote_char (quote_char_reg),
        .step       (step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SKIP;
        end else if (load) begin
            mode_reg <= step.mode_next;
        end
    end

    // Result list: loaded whole, drained from entry 0
    always_comb begin
        list_next = list_reg;
        if (load) begin
            list_next = step.list;
        end else if (m_take) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                list_next.ent[i] = list_reg.ent[i+1];
            end
            list_next.cnt = list_reg.cnt - 3'd1;
        end
    end

    // only the count needs a reset, entries are qualified by it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_reg.cnt <= 3'd0;
        end else begin
            list_reg.cnt <= list_next.cnt;
        end
        list_reg.ent <= list_next.ent;
    end

    // Output
    assign m_tvalid = (list_reg.cnt != 3'd0);
    assign m_tdata  = list_reg.ent[0].ch;
    assign m_tuser  = list_reg.ent[0].kind;
    assign m_tlast  = (list_reg.cnt == 3'd1);

    // Checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        list_reg.cnt <= MAX_RES_C)
        else $error("result count above four");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !load |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending input byte lost");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (list_reg.ent[0].kind == KIND_END) |-> m_tlast)
        else $error("end of input is not the final result of its byte");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (list_reg.ent[0].kind != KIND_CHAR) |-> (list_reg.ent[0].ch == CH_NUL))
        else $error("nonzero character on a mark");

endmodule

FILE: test/tb_text_token_lexer_unit.sv
`timescale 1ns / 1ps

module tb_text_token_lexer_unit;
    import ttl_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          HOLD_AFTER     = 40;
    localparam int          SETTLE_CYCLES  = 5;
    localparam logic [2:0]  QUOTE_ADDR     = {REG_QUOTE, 2'b00};
    localparam logic [2:0]  SPARE_ADDR     = 3'd4;   // no register behind it
    localparam logic [7:0]  PUNCT_SET [0:5] = '{CH_LBRACE, CH_RBRACE, CH_LPAREN,
                                                CH_RPAREN, CH_APOS, CH_COMMA};

    typedef struct {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       last;
    } lex_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    text_token_lexer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Lexer mirror: mode, quote character, and expected token stream
    ttl_mode_t   tok_mode = MODE_SKIP;
    logic [7:0]  quote_ch = QUOTE_RESET;
    lex_result_t byte_results[$];
    lex_result_t expected_tokens[$];
    logic [7:0]  text_bytes[$];

    int unsigned err_cnt   = 0;
    int unsigned bytes_in  = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    function automatic bit is_punct(logic [7:0] b);
        return b inside {CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS, CH_COMMA};
    endfunction

    function void add_token(logic [1:0] k, logic [7:0] c);
        lex_result_t r;
        r.kind     = k;
        r.out_char = (k == KIND_CHAR) ? c : CH_NUL;
        r.last     = 1'b0;
        byte_results.push_back(r);
    endfunction

    function void lex_skip(logic [7:0] b);
        if (b == CH_NUL) begin
            add_token(KIND_END, CH_NUL);
            tok_mode = MODE_SKIP;
        end else if (b <= CH_WS_MAX) begin
            // whitespace is dropped
        end else if (b == CH_SLASH) begin
            tok_mode = MODE_SLASH;
        end else if (b == quote_ch) begin
            tok_mode = MODE_QUOTE;
        end else if (is_punct(b)) begin
            add_token(KIND_CHAR, b);
            add_token(KIND_TEND, CH_NUL);
        end else begin
            add_token(KIND_CHAR, b);
            tok_mode = MODE_WORD;
        end
    endfunction

    // a delimiter closes the word and is then lexed as a fresh token start
    function void lex_word(logic [7:0] b);
        if (is_punct(b) || b <= CH_WS_MAX) begin
            add_token(KIND_TEND, CH_NUL);
            tok_mode = MODE_SKIP;
            lex_skip(b);
        end else begin
            add_token(KIND_CHAR, b);
        end
    endfunction

    function void lex_quoted(logic [7:0] b);
        if (b == CH_NUL) begin
            add_token(KIND_TEND, CH_NUL);
            add_token(KIND_END, CH_NUL);
            tok_mode = MODE_SKIP;
        end else if (b == quote_ch) begin
            add_token(KIND_TEND, CH_NUL);
            tok_mode = MODE_SKIP;
        end else begin
            add_token(KIND_CHAR, b);
        end
    endfunction

    function void lex_byte(logic [7:0] b);
        byte_results.delete();
        case (tok_mode)
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    tok_mode = MODE_COMMENT;
                end else if (quote_ch == CH_SLASH) begin
                    tok_mode = MODE_QUOTE;
                    lex_quoted(b);
                end else begin
                    add_token(KIND_CHAR, CH_SLASH);
                    tok_mode = MODE_WORD;
                    lex_word(b);
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NUL) begin
                    add_token(KIND_END, CH_NUL);
                    tok_mode = MODE_SKIP;
                end else if (b == CH_NEWLINE) begin
                    tok_mode = MODE_SKIP;
                end
            end
            MODE_QUOTE: lex_quoted(b);
            MODE_WORD:  lex_word(b);
            default: begin
                tok_mode = MODE_SKIP;
                lex_skip(b);
            end
        endcase
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].last = 1'b1;
        end
        foreach (byte_results[i]) expected_tokens.push_back(byte_results[i]);
    endfunction

    // Per-request wait, with runs of back-to-back traffic
    function automatic int unsigned draw_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0) burst = !burst;
        if (burst || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Driver
    int unsigned tx_gap   = 0;
    bit          tx_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                lex_byte(s_tdata);
                bytes_in <= bytes_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (text_bytes.size() > 0) begin
                    s_tdata  <= text_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    tx_gap   <= draw_wait(tx_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long output hold-off so the input side backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_in >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor and checker
    int unsigned rx_gap   = 0;
    bit          rx_burst = 1'b0;

    always @(posedge aclk) begin
        lex_result_t exp_r;
        int unsigned w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            w = rx_gap;
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result: kind %0d out_char 0x%02h last %0d",
                           m_tuser, m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    exp_r = expected_tokens.pop_front();
                    if (m_tuser !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, m_tuser);
                        err_cnt++;
                    end
                    if (m_tdata !== exp_r.out_char) begin
                        $error("out_char: expected 0x%02h, got 0x%02h",
                               exp_r.out_char, m_tdata);
                        err_cnt++;
                    end
                    if (m_tlast !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                        err_cnt++;
                    end
                end
                w = draw_wait(rx_burst);
            end else if (w != 0) begin
                w = w - 1;
            end
            rx_gap   <= w;
            m_tready <= (w == 0) && (hold_left == 0);
        end
    end

    // Watchdog: no request moving on either side for too long
    int unsigned stuck_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_text_token_lexer_unit: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Register access
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr[2] == REG_QUOTE) quote_ch = data[7:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("quote_char readback: expected 0x%08h, got 0x%08h", want, prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_quote(input logic [7:0] q);
        apb_write(QUOTE_ADDR, {24'h0, q});
        apb_check(QUOTE_ADDR, {24'h0, q});
    endtask

    // Wait until every byte is taken and every token seen, then let the
    // pipeline empty out for bytes that produce nothing
    task automatic drain;
        do @(posedge aclk);
        while (text_bytes.size() != 0 || s_tvalid || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Text generation
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255));
        while (c == CH_SLASH || c == quote_ch || is_punct(c));
        return c;
    endfunction

    task automatic gen_text(input int n);
        int         start;
        int         len;
        logic [7:0] c;
        start = text_bytes.size();
        while (text_bytes.size() - start < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    len = $urandom_range(1, 6);
                    repeat (len) text_bytes.push_back(word_char());
                end
                2: begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_bytes.push_back(8'($urandom_range(1, 32)));
                end
                3: text_bytes.push_back(PUNCT_SET[$urandom_range(0, 5)]);
                4: begin
                    // line comment, sometimes cut short by end of input
                    text_bytes.push_back(CH_SLASH);
                    text_bytes.push_back(CH_SLASH);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        do c = 8'($urandom_range(1, 255)); while (c == CH_NEWLINE);
                        text_bytes.push_back(c);
                    end
                    text_bytes.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_NEWLINE);
                end
                5: begin
                    // quoted token, sometimes closed by end of input
                    text_bytes.push_back(quote_ch);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        do c = 8'($urandom_range(1, 255)); while (c == quote_ch);
                        text_bytes.push_back(c);
                    end
                    text_bytes.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : quote_ch);
                end
                6: begin
                    text_bytes.push_back(CH_SLASH);
                    text_bytes.push_back(($urandom_range(0, 1) == 0) ? word_char()
                                          : PUNCT_SET[$urandom_range(0, 5)]);
                end
                7: text_bytes.push_back(CH_NUL);
                default: begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_bytes.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Sequence
    initial begin
        logic [7:0] directed [];
        logic [7:0] quote_list [];

        directed = '{
            8'h41, 8'hFF, CH_COMMA,                              // word closed by comma
            CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS,
            8'h01, CH_WS_MAX,                                    // whitespace limits
            CH_SLASH, 8'h78, CH_LPAREN,                          // lone slash word
            CH_SLASH, CH_SLASH, 8'h7F, CH_NEWLINE,               // comment
            QUOTE_RESET, QUOTE_RESET,                            // empty quoted token
            QUOTE_RESET, CH_NUL,                                 // zero inside quotes
            CH_SLASH, CH_LPAREN,                                 // four tokens from one byte
            CH_NUL, 8'h21
        };
        quote_list = '{8'hFF, CH_SLASH, CH_LPAREN, 8'h00, CH_WS_MAX,
                       8'($urandom_range(33, 254)), QUOTE_RESET};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        apb_check(QUOTE_ADDR, {24'h0, QUOTE_RESET});
        apb_write(SPARE_ADDR, {24'h0, CH_SLASH});
        set_quote(QUOTE_RESET);

        foreach (directed[i]) text_bytes.push_back(directed[i]);
        gen_text(10);
        drain();

        foreach (quote_list[i]) begin
            set_quote(quote_list[i]);
            gen_text(31);
            drain();
        end

        if (err_cnt == 0 && expected_tokens.size() == 0) begin
            $display("tb_text_token_lexer_unit: done, clean");
        end else begin
            $display("tb_text_token_lexer_unit: done, errors");
        end
        $finish;
    end

endmodule
